// ----- sv/button_mode_spray_controller_macros.svh -----
// Assertion macros for the button mode spray controller.
// Used by the top level; no other dependencies.
`ifndef BUTTON_MODE_SPRAY_CONTROLLER_MACROS_SVH
`define BUTTON_MODE_SPRAY_CONTROLLER_MACROS_SVH
`ifndef SYNTH
`define BMSC_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) prop) \
    else $error("bmsc assertion failed");
`define BMSC_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("bmsc assertion failed");
`else
`define BMSC_ASSERT(lbl, clk_s, rstn_s, prop)
`define BMSC_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif
`endif

// ----- sv/bmsc_pkg.sv -----
// Types and constants for the button mode spray controller.
// No dependencies.
`timescale 1ns / 1ps
package bmsc_pkg;

  localparam logic [2:0] MODE_OFF      = 3'd0;
  localparam logic [2:0] MODE_BOTH     = 3'd1;
  localparam logic [2:0] MODE_LEFT     = 3'd2;
  localparam logic [2:0] MODE_RIGHT    = 3'd3;
  localparam logic [2:0] MODE_INTERVAL = 3'd4;

  localparam logic [2:0] CFG_DEBOUNCE   = 3'd0;
  localparam logic [2:0] CFG_LONG_PRESS = 3'd1;
  localparam logic [2:0] CFG_LED_TMO    = 3'd2;
  localparam logic [2:0] CFG_HALF_SEC   = 3'd3;
  localparam logic [2:0] CFG_PHASES     = 3'd4;
  localparam logic [2:0] CFG_SPRAY_ON   = 3'd5;
  localparam logic [2:0] CFG_CONT_LIM   = 3'd6;
  localparam logic [2:0] CFG_INT_LIM    = 3'd7;

  localparam int CFG_DATA_W = 14;

  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [9:0]  long_press_ticks;
    logic [10:0] led_timeout_ticks;
    logic [6:0]  ticks_per_half_second;
    logic [3:0]  phases_per_cycle;
    logic [3:0]  spray_on_phases;
    logic [13:0] continuous_limit;
    logic [13:0] interval_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    debounce_ticks:        8'd8,
    long_press_ticks:      10'd300,
    led_timeout_ticks:     11'd1000,
    ticks_per_half_second: 7'd50,
    phases_per_cycle:      4'd12,
    spray_on_phases:       4'd6,
    continuous_limit:      14'd7200,
    interval_limit:        14'd9600
  };

  typedef struct packed {
    logic [9:0]  press_count;
    logic        long_seen;
    logic [2:0]  mode;
    logic        led_en;
    logic [10:0] led_timer;
    logic [6:0]  tick_in_phase;
    logic [3:0]  phase_index;
    logic [13:0] session_cycles;
    logic        drv_left;
    logic        drv_right;
    logic        drv_led;
  } state_t;

  localparam state_t STATE_RESET = '{
    press_count:    10'd0,
    long_seen:      1'b0,
    mode:           MODE_OFF,
    led_en:         1'b0,
    led_timer:      11'd0,
    tick_in_phase:  7'd0,
    phase_index:    4'd0,
    session_cycles: 14'd0,
    drv_left:       1'b0,
    drv_right:      1'b0,
    drv_led:        1'b1
  };

endpackage

// ----- sv/button_mode_spray_controller.sv -----
// Button mode spray controller: top level with config, state and result registers.
// Depends on bmsc_pkg, bmsc_step and button_mode_spray_controller_macros.svh.
//
// Usage:
// - Input channel (in_valid/in_ready/in_key_level): one transaction per 10 ms tick,
//   carrying the button level.
// - Result channel (out_valid/out_ready/out_*): one transaction per input tick with
//   head drives, LED, sleep request, current mode and LED enable after that tick.
// - Config port (cfg_we/cfg_index/cfg_wdata): single-cycle register writes, no
//   read-back; write only while no tick is in flight.
// Result: registered, and valid in the cycle after its tick is accepted.
// Throughput: one tick per cycle while out_ready is high; the whole per-tick update is one pass of
// combinational logic from the state register to the result register.
// Reset: synchronous, active low; config and state registers return to their default values,
// state clears with the LED bit set, and no result is pending.
// Stall: while out_ready is low the result holds; a new tick is still taken
// in the same cycle that the pending result leaves.
`timescale 1ns / 1ps
`include "button_mode_spray_controller_macros.svh"
module button_mode_spray_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [13:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_key_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_left_spray,
  output logic        out_right_spray,
  output logic        out_led_lit,
  output logic        out_sleep_request,
  output logic [2:0]  out_mode_now,
  output logic        out_led_enabled
);

  bmsc_pkg::cfg_t   cfg_r;
  bmsc_pkg::state_t st_r;
  bmsc_pkg::state_t st_nxt;
  logic             slept;
  logic             out_valid_r;
  logic             left_r, right_r, led_r, sleep_r, led_en_r;
  logic [2:0]       mode_r;
  logic             in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= bmsc_pkg::CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bmsc_pkg::CFG_DEBOUNCE:   cfg_r.debounce_ticks        <= cfg_wdata[7:0];
        bmsc_pkg::CFG_LONG_PRESS: cfg_r.long_press_ticks      <= cfg_wdata[9:0];
        bmsc_pkg::CFG_LED_TMO:    cfg_r.led_timeout_ticks     <= cfg_wdata[10:0];
        bmsc_pkg::CFG_HALF_SEC:   cfg_r.ticks_per_half_second <= cfg_wdata[6:0];
        bmsc_pkg::CFG_PHASES:     cfg_r.phases_per_cycle      <= cfg_wdata[3:0];
        bmsc_pkg::CFG_SPRAY_ON:   cfg_r.spray_on_phases       <= cfg_wdata[3:0];
        bmsc_pkg::CFG_CONT_LIM:   cfg_r.continuous_limit      <= cfg_wdata;
        bmsc_pkg::CFG_INT_LIM:    cfg_r.interval_limit        <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  bmsc_step u_step (
    .cfg       (cfg_r),
    .st        (st_r),
    .key_level (in_key_level),
    .st_nxt    (st_nxt),
    .slept     (slept)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= bmsc_pkg::STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      left_r   <= st_nxt.drv_left;
      right_r  <= st_nxt.drv_right;
      led_r    <= st_nxt.drv_led;
      sleep_r  <= slept;
      mode_r   <= st_nxt.mode;
      led_en_r <= st_nxt.led_en;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_left_spray    = left_r;
  assign out_right_spray   = right_r;
  assign out_led_lit       = led_r;
  assign out_sleep_request = sleep_r;
  assign out_mode_now      = mode_r;
  assign out_led_enabled   = led_en_r;

  `BMSC_ASSERT(a_accept_gives_result, clk, rst_n, in_fire |=> out_valid_r)
  `BMSC_ASSERT(a_sleep_clears_outputs, clk, rst_n, (out_valid_r && sleep_r) |-> (mode_r == bmsc_pkg::MODE_OFF && !left_r && !right_r && !led_r))
  `BMSC_ASSERT(a_left_mode_drive, clk, rst_n, (out_valid_r && mode_r == bmsc_pkg::MODE_LEFT) |-> (left_r && !right_r))
  `BMSC_ASSERT(a_led_en_only_on_tick, clk, rst_n, !in_fire |=> $stable(st_r.led_en))
  `BMSC_ASSERT_ALWAYS(a_reset_empties_output, clk, !rst_n |=> !out_valid_r)

endmodule

// ----- sv/bmsc_step.sv -----
// Next-state logic for one tick: LED drive, button decode, timekeeping.
// Depends on bmsc_pkg.
`timescale 1ns / 1ps
module bmsc_step (
  input  bmsc_pkg::cfg_t   cfg,
  input  bmsc_pkg::state_t st,
  input  logic             key_level,
  output bmsc_pkg::state_t st_nxt,
  output logic             slept
);

  always_comb begin
    bmsc_pkg::state_t n;
    logic [10:0] hold;
    logic [13:0] limit;
    logic        click_short;
    logic        click_long;
    logic        on;

    n           = st;
    slept       = 1'b0;
    click_short = 1'b0;
    click_long  = 1'b0;
    on          = 1'b0;
    limit       = cfg.continuous_limit;
    hold        = (cfg.led_timeout_ticks == 11'h7FF) ? 11'h7FF
                                                     : cfg.led_timeout_ticks + 11'd1;

    // drive and LED
    if (n.led_timer != 11'h7FF) n.led_timer = n.led_timer + 11'd1;
    if (n.led_timer >= cfg.led_timeout_ticks) begin
      if (!n.led_en) n.drv_led = 1'b0;
      n.led_timer = hold;
    end
    if (n.led_en) n.drv_led = 1'b1;
    if (n.mode == bmsc_pkg::MODE_INTERVAL) begin
      on          = n.phase_index < cfg.spray_on_phases;
      n.drv_left  = on;
      n.drv_right = on;
    end

    // button decode
    if (key_level) begin
      if (n.press_count != 10'h3FF) n.press_count = n.press_count + 10'd1;
      if (n.press_count >= cfg.long_press_ticks) begin
        n.press_count = cfg.long_press_ticks;
        if (!n.long_seen) begin
          n.long_seen = 1'b1;
          click_long  = 1'b1;
        end
      end
    end else begin
      if (n.press_count >= cfg.long_press_ticks) begin
        n.long_seen = 1'b0;
      end else if (n.press_count >= {2'b00, cfg.debounce_ticks}) begin
        click_short = 1'b1;
      end
      n.press_count = 10'd0;
    end

    if (click_short) begin
      n.mode = (n.mode >= bmsc_pkg::MODE_INTERVAL) ? bmsc_pkg::MODE_OFF : n.mode + 3'd1;
      case (n.mode)
        bmsc_pkg::MODE_OFF: begin
          n.drv_left  = 1'b0;
          n.drv_right = 1'b0;
        end
        bmsc_pkg::MODE_BOTH: begin
          n.drv_left  = 1'b1;
          n.drv_right = 1'b1;
        end
        bmsc_pkg::MODE_LEFT: begin
          n.drv_left  = 1'b1;
          n.drv_right = 1'b0;
        end
        bmsc_pkg::MODE_RIGHT: begin
          n.drv_left  = 1'b0;
          n.drv_right = 1'b1;
        end
        default: begin
        end
      endcase
    end else if (click_long) begin
      if (n.led_en) begin
        n.led_en    = 1'b0;
        n.led_timer = hold;
      end else begin
        n.led_en = 1'b1;
      end
    end

    // timekeeping
    if (n.tick_in_phase != 7'h7F) n.tick_in_phase = n.tick_in_phase + 7'd1;
    if (n.tick_in_phase >= cfg.ticks_per_half_second) begin
      n.tick_in_phase = 7'd0;
      if (n.phase_index != 4'hF) n.phase_index = n.phase_index + 4'd1;
      if (n.phase_index >= cfg.phases_per_cycle) begin
        limit = (n.mode < bmsc_pkg::MODE_INTERVAL) ? cfg.continuous_limit
                                                   : cfg.interval_limit;
        n.phase_index = 4'd0;
        if (n.session_cycles != 14'h3FFF) n.session_cycles = n.session_cycles + 14'd1;
        if (n.session_cycles >= limit) begin
          n.session_cycles = 14'd0;
          n.mode           = bmsc_pkg::MODE_OFF;
          n.drv_left       = 1'b0;
          n.drv_right      = 1'b0;
          n.drv_led        = 1'b0;
          slept            = 1'b1;
        end
        if (n.mode == bmsc_pkg::MODE_OFF && n.led_timer >= cfg.led_timeout_ticks
            && !n.led_en) begin
          n.session_cycles = 14'd0;
          n.drv_left       = 1'b0;
          n.drv_right      = 1'b0;
          n.drv_led        = 1'b0;
          slept            = 1'b1;
        end
      end
    end

    st_nxt = n;
  end

endmodule

// ----- verif/tb_button_mode_spray_controller.sv -----
// Self-checking testbench for button_mode_spray_controller: ticks go in, one result per tick
// is compared against a cycle-free predictor, over directed and random button sequences.
// Depends on bmsc_pkg and the controller RTL.
`timescale 1ns / 1ps
module tb_button_mode_spray_controller;

  typedef struct packed {
    logic       left_on;
    logic       right_on;
    logic       led_on;
    logic       slept;
    logic [2:0] mode;
    logic       led_en;
  } tick_out_t;

  typedef struct packed {
    logic      key;
    logic      retune;
    logic      typed;
    tick_out_t want;
  } script_row_t;

  typedef enum logic [1:0] {PRESS_NONE, PRESS_SHORT, PRESS_LONG} press_t;

  localparam tick_out_t AFTER_RESET = '{left_on: 1'b0, right_on: 1'b0, led_on: 1'b1,
                                        slept: 1'b0, mode: bmsc_pkg::MODE_OFF,
                                        led_en: 1'b0};

  localparam bmsc_pkg::cfg_t TIGHT = '{8'd2, 10'd4, 11'd3, 7'd1, 4'd2, 4'd1, 14'd40, 14'd9};

  localparam script_row_t OPENING [26] = '{
    '{1'b0, 1'b0, 1'b1, AFTER_RESET},
    '{1'b1, 1'b1, 1'b0, '0}, '{1'b1, 1'b0, 1'b0, '0}, '{1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, '0}, '{1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, '0}, '{1'b1, 1'b0, 1'b0, '0}, '{1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, '0}, '{1'b1, 1'b0, 1'b0, '0}, '{1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, '0}, '{1'b1, 1'b0, 1'b0, '0}, '{1'b0, 1'b0, 1'b0, '0},
    '{1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, '0}, '{1'b1, 1'b0, 1'b0, '0}, '{1'b1, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, '0}, '{1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, '0}, '{1'b1, 1'b0, 1'b0, '0}, '{1'b1, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, '0}, '{1'b0, 1'b0, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = bmsc_pkg::CFG_DEBOUNCE;
  logic [13:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_key_level = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_left_spray;
  logic        out_right_spray;
  logic        out_led_lit;
  logic        out_sleep_request;
  logic [2:0]  out_mode_now;
  logic        out_led_enabled;

  bmsc_pkg::cfg_t   settings = bmsc_pkg::CFG_RESET;
  bmsc_pkg::state_t shadow = bmsc_pkg::STATE_RESET;
  tick_out_t        awaited_ticks[$];
  bit               failed = 1'b0;
  bit               quiet = 1'b0;
  bit               hold_off_go = 1'b0;
  bit               hold_off_done = 1'b0;
  int               stall_left = 0;

  button_mode_spray_controller uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_key_level(in_key_level),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_left_spray(out_left_spray), .out_right_spray(out_right_spray),
    .out_led_lit(out_led_lit), .out_sleep_request(out_sleep_request),
    .out_mode_now(out_mode_now), .out_led_enabled(out_led_enabled)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic [10:0] led_hold_value();
    logic [11:0] v;
    v = {1'b0, settings.led_timeout_ticks} + 12'd1;
    if (v > 12'd2047) v = 12'd2047;
    return v[10:0];
  endfunction

  function automatic void go_to_sleep();
    shadow.session_cycles = '0;
    shadow.mode = bmsc_pkg::MODE_OFF;
    shadow.drv_left = 1'b0;
    shadow.drv_right = 1'b0;
    shadow.drv_led = 1'b0;
  endfunction

  function automatic tick_out_t next_tick_outputs(input logic key);
    press_t      press;
    logic        on;
    logic        slept;
    logic [13:0] limit;
    tick_out_t   r;
    slept = 1'b0;
    press = PRESS_NONE;

    if (shadow.led_timer != 11'h7FF) shadow.led_timer = shadow.led_timer + 11'd1;
    if (shadow.led_timer >= settings.led_timeout_ticks) begin
      if (!shadow.led_en) shadow.drv_led = 1'b0;
      shadow.led_timer = led_hold_value();
    end
    if (shadow.led_en) shadow.drv_led = 1'b1;
    if (shadow.mode == bmsc_pkg::MODE_INTERVAL) begin
      on = shadow.phase_index < settings.spray_on_phases;
      shadow.drv_left = on;
      shadow.drv_right = on;
    end

    if (key) begin
      if (shadow.press_count != 10'h3FF) shadow.press_count = shadow.press_count + 10'd1;
      if (shadow.press_count >= settings.long_press_ticks) begin
        shadow.press_count = settings.long_press_ticks;
        if (!shadow.long_seen) begin
          shadow.long_seen = 1'b1;
          press = PRESS_LONG;
        end
      end
    end else if (shadow.press_count >= settings.long_press_ticks) begin
      shadow.press_count = '0;
      shadow.long_seen = 1'b0;
    end else begin
      if (shadow.press_count >= settings.debounce_ticks) press = PRESS_SHORT;
      shadow.press_count = '0;
    end

    if (press == PRESS_SHORT) begin
      shadow.mode = shadow.mode + 3'd1;
      if (shadow.mode > bmsc_pkg::MODE_INTERVAL) shadow.mode = bmsc_pkg::MODE_OFF;
      case (shadow.mode)
        bmsc_pkg::MODE_OFF: begin
          shadow.drv_left = 1'b0;
          shadow.drv_right = 1'b0;
        end
        bmsc_pkg::MODE_BOTH: begin
          shadow.drv_left = 1'b1;
          shadow.drv_right = 1'b1;
        end
        bmsc_pkg::MODE_LEFT: begin
          shadow.drv_left = 1'b1;
          shadow.drv_right = 1'b0;
        end
        bmsc_pkg::MODE_RIGHT: begin
          shadow.drv_left = 1'b0;
          shadow.drv_right = 1'b1;
        end
        default: ;
      endcase
    end else if (press == PRESS_LONG) begin
      if (shadow.led_en) begin
        shadow.led_en = 1'b0;
        shadow.led_timer = led_hold_value();
      end else begin
        shadow.led_en = 1'b1;
      end
    end

    if (shadow.tick_in_phase != 7'h7F) shadow.tick_in_phase = shadow.tick_in_phase + 7'd1;
    if (shadow.tick_in_phase >= settings.ticks_per_half_second) begin
      shadow.tick_in_phase = '0;
      if (shadow.phase_index != 4'hF) shadow.phase_index = shadow.phase_index + 4'd1;
      if (shadow.phase_index >= settings.phases_per_cycle) begin
        limit = (shadow.mode < bmsc_pkg::MODE_INTERVAL) ? settings.continuous_limit
                                                        : settings.interval_limit;
        shadow.phase_index = '0;
        if (shadow.session_cycles != 14'h3FFF)
          shadow.session_cycles = shadow.session_cycles + 14'd1;
        if (shadow.session_cycles >= limit) begin
          go_to_sleep();
          slept = 1'b1;
        end
        if (shadow.mode == bmsc_pkg::MODE_OFF &&
            shadow.led_timer >= settings.led_timeout_ticks && !shadow.led_en) begin
          go_to_sleep();
          slept = 1'b1;
        end
      end
    end

    r.left_on = shadow.drv_left;
    r.right_on = shadow.drv_right;
    r.led_on = shadow.drv_led;
    r.slept = slept;
    r.mode = shadow.mode;
    r.led_en = shadow.led_en;
    return r;
  endfunction

  function automatic bmsc_pkg::cfg_t pick_settings(input int phase);
    bmsc_pkg::cfg_t c;
    case (phase)
      0: c = bmsc_pkg::CFG_RESET;
      1: c = '{8'd255, 10'd1023, 11'd2046, 7'd127, 4'd15, 4'd15, 14'd16383, 14'd16383};
      2: c = '0;
      3: c = '{8'd1, 10'd2, 11'd1, 7'd1, 4'd2, 4'd0, 14'd1, 14'd1};
      default: begin
        c.debounce_ticks = 8'($urandom_range(0, 6));
        c.long_press_ticks = 10'($urandom_range(0, 24));
        c.led_timeout_ticks = ($urandom_range(0, 7) == 0) ? 11'h7FF
                                                          : 11'($urandom_range(0, 80));
        c.ticks_per_half_second = 7'($urandom_range(0, 3));
        c.phases_per_cycle = 4'($urandom_range(0, 15));
        c.spray_on_phases = 4'($urandom_range(0, 15));
        c.continuous_limit = 14'($urandom_range(0, 30));
        c.interval_limit = 14'($urandom_range(0, 30));
      end
    endcase
    return c;
  endfunction

  task automatic offer_tick(input logic key, input logic typed = 1'b0,
                            input tick_out_t want = '0);
    tick_out_t predicted;
    if (!quiet) begin
      while ($urandom_range(0, 99) < 6) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_key_level <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = next_tick_outputs(key);
    awaited_ticks.push_back(typed ? want : predicted);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (awaited_ticks.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [13:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic apply_settings(input bmsc_pkg::cfg_t c);
    drain();
    write_reg(bmsc_pkg::CFG_DEBOUNCE, 14'(c.debounce_ticks));
    write_reg(bmsc_pkg::CFG_LONG_PRESS, 14'(c.long_press_ticks));
    write_reg(bmsc_pkg::CFG_LED_TMO, 14'(c.led_timeout_ticks));
    write_reg(bmsc_pkg::CFG_HALF_SEC, 14'(c.ticks_per_half_second));
    write_reg(bmsc_pkg::CFG_PHASES, 14'(c.phases_per_cycle));
    write_reg(bmsc_pkg::CFG_SPRAY_ON, 14'(c.spray_on_phases));
    write_reg(bmsc_pkg::CFG_CONT_LIM, c.continuous_limit);
    write_reg(bmsc_pkg::CFG_INT_LIM, c.interval_limit);
    cfg_we <= 1'b0;
    settings = c;
  endtask

  always @(posedge clk) begin
    if (hold_off_go && !hold_off_done) begin
      hold_off_done <= 1'b1;
      stall_left <= 80;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(0, 99) >= 6);
    end
  end

  always @(posedge clk) begin : check_results
    tick_out_t w;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_ticks.size() == 0) begin
        $error("result transaction with no tick outstanding");
        failed = 1'b1;
      end else begin
        w = awaited_ticks.pop_front();
        if (out_left_spray !== w.left_on) begin
          $error("left_spray: expected %0d, got %0d", w.left_on, out_left_spray);
          failed = 1'b1;
        end
        if (out_right_spray !== w.right_on) begin
          $error("right_spray: expected %0d, got %0d", w.right_on, out_right_spray);
          failed = 1'b1;
        end
        if (out_led_lit !== w.led_on) begin
          $error("led_lit: expected %0d, got %0d", w.led_on, out_led_lit);
          failed = 1'b1;
        end
        if (out_sleep_request !== w.slept) begin
          $error("sleep_request: expected %0d, got %0d", w.slept, out_sleep_request);
          failed = 1'b1;
        end
        if (out_mode_now !== w.mode) begin
          $error("mode_now: expected %0d, got %0d", w.mode, out_mode_now);
          failed = 1'b1;
        end
        if (out_led_enabled !== w.led_en) begin
          $error("led_enabled: expected %0d, got %0d", w.led_en, out_led_enabled);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    bmsc_pkg::cfg_t c;
    int   sent;
    int   kind;
    int   hold;
    int   gap;
    int   deb;
    int   lng;
    bit   did_long;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    shadow = bmsc_pkg::STATE_RESET;
    settings = bmsc_pkg::CFG_RESET;

    foreach (OPENING[i]) begin
      if (OPENING[i].retune) apply_settings(TIGHT);
      offer_tick(OPENING[i].key, OPENING[i].typed, OPENING[i].want);
    end

    for (int phase = 0; phase < 9; phase++) begin
      c = pick_settings(phase);
      apply_settings(c);
      // block the result side for a while so the input stalls
      if (phase == 4) hold_off_go = 1'b1;
      quiet = (phase == 5);
      deb = c.debounce_ticks;
      lng = c.long_press_ticks;
      sent = 0;
      did_long = 1'b0;
      while (sent < 100) begin
        kind = $urandom_range(0, 9);
        if (kind >= 7 && kind <= 8 && lng > 64 && did_long) kind = 3;
        if (kind == 9) begin
          gap = $urandom_range(1, 8);
          repeat (gap) offer_tick(1'($urandom_range(0, 1)));
          sent += gap;
        end else begin
          if (kind < 2) begin
            hold = $urandom_range(0, deb);
          end else if (kind < 7) begin
            hold = deb + $urandom_range(0, 12);
            if (lng > 0 && hold >= lng) hold = lng - 1;
          end else begin
            hold = lng + $urandom_range(0, 4);
            did_long = 1'b1;
          end
          gap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 6);
          repeat (hold) offer_tick(1'b1);
          repeat (gap) offer_tick(1'b0);
          sent += hold + gap;
        end
      end
    end
    quiet = 1'b0;

    in_valid <= 1'b0;
    while (awaited_ticks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (!failed) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
